@@ src/bkas_pkg.sv @@
package bkas_pkg;

  // Configuration register set as seen by the datapath.
  typedef struct packed {
    logic signed [31:0] acceleration;
    logic        [30:0] max_step;
    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;
    logic signed [31:0] velocity_cap;
    logic               frozen;
  } cfg_t;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_ACCELERATION = 3'd0;
  localparam logic [2:0] REG_MAX_STEP     = 3'd1;
  localparam logic [2:0] REG_LOW_BOUND    = 3'd2;
  localparam logic [2:0] REG_HIGH_BOUND   = 3'd3;
  localparam logic [2:0] REG_VELOCITY_CAP = 3'd4;
  localparam logic [2:0] REG_FROZEN       = 3'd5;

  // Datapath operations.
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE    = 4'd0;
  localparam op_t OP_START   = 4'd1;
  localparam op_t OP_MUL_S0  = 4'd2;
  localparam op_t OP_MUL_T   = 4'd3;
  localparam op_t OP_MUL_VV  = 4'd4;
  localparam op_t OP_MUL_AX  = 4'd5;
  localparam op_t OP_ADD     = 4'd6;
  localparam op_t OP_SH_S0   = 4'd7;
  localparam op_t OP_SH_T    = 4'd8;
  localparam op_t OP_LIMIT   = 4'd9;
  localparam op_t OP_DISC    = 4'd10;
  localparam op_t OP_SQRT    = 4'd11;
  localparam op_t OP_ARR_END = 4'd12;
  localparam op_t OP_BOUND   = 4'd13;
  localparam op_t OP_CAP     = 4'd14;

  typedef struct packed {
    op_t  op;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic limited;
    logic bound_hit;
    logic a_zero;
  } stat_t;

endpackage

@@ src/bkas_dpath.sv @@
module bkas_dpath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bkas_pkg::cfg_t      cfg,
  input  bkas_pkg::cmd_t      cmd,
  output bkas_pkg::stat_t     stat,
  input  logic [31:0]         in_dt,
  input  logic signed [31:0]  in_lpos,
  input  logic signed [31:0]  in_lvel,
  output logic signed [31:0]  pos,
  output logic signed [31:0]  vel,
  output logic signed [31:0]  disp,
  output logic signed [31:0]  prev,
  output logic [47:0]         elapsed
);

  localparam logic [65:0] MASK_F = (66'd1 << FRAC_BITS) - 66'd1;
  localparam logic [65:0] MASK_T = (66'd1 << (FRAC_BITS + 1)) - 66'd1;

  logic signed [31:0] pos_r, vel_r, disp_r, prev_r, s0_r, t_r, d_r;
  logic [47:0]        time_r;
  logic [31:0]        dt_r;
  logic signed [33:0] x_r;
  logic [63:0]        plo_r, v2_r, rad_r;
  logic [33:0]        phi_r, rem_r;
  logic [65:0]        prod_r;
  logic               neg_r, qneg_r;
  logic [31:0]        root_r;

  logic signed [33:0] a_ext, v_ext, xt;
  logic [33:0]        a_mag, v_mag, xt_mag, x_mag, mul_mag;
  logic [31:0]        mul_y;
  logic               mul_neg;
  logic signed [31:0] max_s, sh_res;
  logic               lim_hi, lim_lo;
  logic signed [32:0] n, hi_ext, lo_ext, pos_ext;
  logic               hit_hi, hit_lo;
  logic [63:0]        disc;
  logic [35:0]        rem_cat, trial;
  logic [31:0]        root_sat;

  function automatic logic [31:0] fix_res(input logic [65:0] q, input logic rnz,
                                          input logic neg);
    logic [66:0] qq;
    qq = {1'b0, q} + {66'd0, (neg & rnz)};
    if (neg) begin
      if (qq > 67'h80000000) return 32'h80000000;
      return 32'(-qq[31:0]);
    end
    if (qq > 67'h7fffffff) return 32'h7fffffff;
    return qq[31:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [32:0] v);
    if (v > 33'sh0_7fffffff) return 32'h7fffffff;
    if (v < -33'sh0_80000000) return 32'h80000000;
    return v[31:0];
  endfunction

  always_comb begin
    a_ext   = {{2{cfg.acceleration[31]}}, cfg.acceleration};
    a_mag   = a_ext[33] ? 34'(-a_ext) : a_ext;
    v_ext   = {{2{vel_r[31]}}, vel_r};
    v_mag   = v_ext[33] ? 34'(-v_ext) : v_ext;
    xt      = {vel_r[31], vel_r, 1'b0} + {{2{s0_r[31]}}, s0_r};
    xt_mag  = xt[33] ? 34'(-xt) : xt;
    x_mag   = x_r[33] ? 34'(-x_r) : x_r;
    case (cmd.op)
      bkas_pkg::OP_MUL_S0: begin
        mul_mag = a_mag;  mul_y = dt_r;        mul_neg = a_ext[33];
      end
      bkas_pkg::OP_MUL_T: begin
        mul_mag = xt_mag; mul_y = dt_r;        mul_neg = xt[33];
      end
      bkas_pkg::OP_MUL_VV: begin
        mul_mag = v_mag;  mul_y = v_mag[31:0]; mul_neg = 1'b0;
      end
      default: begin
        mul_mag = x_mag;  mul_y = a_mag[31:0]; mul_neg = 1'b0;
      end
    endcase

    if (cmd.op == bkas_pkg::OP_SH_T) begin
      sh_res = fix_res(prod_r >> (FRAC_BITS + 1), |(prod_r & MASK_T), neg_r);
    end else begin
      sh_res = fix_res(prod_r >> FRAC_BITS, |(prod_r & MASK_F), neg_r);
    end

    max_s  = {1'b0, cfg.max_step};
    lim_hi = t_r > max_s;
    lim_lo = t_r < -max_s;

    pos_ext = {pos_r[31], pos_r};
    n       = pos_ext + {d_r[31], d_r};
    hi_ext  = {cfg.high_bound[31], cfg.high_bound};
    lo_ext  = {cfg.low_bound[31], cfg.low_bound};
    hit_hi  = n > hi_ext;
    hit_lo  = !hit_hi && (n < lo_ext);

    if (prod_r == 66'd0) begin
      disc = v2_r;
    end else if (!qneg_r) begin
      if (prod_r >= 66'h0_2000_0000_0000_0000) disc = 64'h4000_0000_0000_0000;
      else disc = v2_r + {prod_r[62:0], 1'b0};
    end else begin
      if (prod_r >= 66'h0_4000_0000_0000_0000 || {prod_r, 1'b0} >= {3'd0, v2_r})
        disc = 64'd0;
      else disc = v2_r - {prod_r[62:0], 1'b0};
    end

    rem_cat  = {rem_r, rad_r[63:62]};
    trial    = {2'b00, root_r, 2'b01};
    root_sat = root_r[31] ? 32'h7fffffff : root_r;

    stat.limited   = lim_hi | lim_lo;
    stat.bound_hit = hit_hi | hit_lo;
    stat.a_zero    = cfg.acceleration == 32'sd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      vel_r  <= '0;
      disp_r <= '0;
      time_r <= '0;
      prev_r <= '0;
    end else begin
      case (cmd.op)
        bkas_pkg::OP_START: begin
          prev_r <= pos_r;
          if (cmd.load) begin
            pos_r <= in_lpos;
            vel_r <= in_lvel;
          end else begin
            time_r <= time_r + {16'd0, in_dt};
          end
        end
        bkas_pkg::OP_LIMIT: begin
          if (lim_hi)      d_r <= max_s;
          else if (lim_lo) d_r <= -max_s;
          else             d_r <= t_r;
          x_r <= lim_hi ? {2'b00, max_s} : lim_lo ? 34'(-{2'b00, max_s})
                                                 : {{2{t_r[31]}}, t_r};
        end
        bkas_pkg::OP_ARR_END: vel_r <= (vel_r > 32'sd0) ? root_sat : 32'(-root_sat);
        bkas_pkg::OP_BOUND: begin
          if (hit_hi) begin
            x_r    <= {hi_ext[32], hi_ext} - {n[32], n};
            disp_r <= sat32(hi_ext - pos_ext);
            pos_r  <= cfg.high_bound;
          end else if (hit_lo) begin
            x_r    <= {lo_ext[32], lo_ext} - {n[32], n};
            disp_r <= sat32(lo_ext - pos_ext);
            pos_r  <= cfg.low_bound;
          end else begin
            disp_r <= d_r;
            pos_r  <= n[31:0];
            vel_r  <= sat32({vel_r[31], vel_r} + {s0_r[31], s0_r});
          end
        end
        bkas_pkg::OP_CAP: if (vel_r > cfg.velocity_cap) vel_r <= cfg.velocity_cap;
        default: ;
      endcase
    end
  end

  // Arithmetic registers; they carry no control meaning and need no reset.
  always_ff @(posedge clk) begin
    case (cmd.op)
      bkas_pkg::OP_START: dt_r <= in_dt;
      bkas_pkg::OP_MUL_S0, bkas_pkg::OP_MUL_T, bkas_pkg::OP_MUL_VV,
      bkas_pkg::OP_MUL_AX: begin
        plo_r <= {32'd0, mul_mag[31:0]} * {32'd0, mul_y};
        phi_r <= {32'd0, mul_mag[33:32]} * {2'd0, mul_y};
        neg_r <= mul_neg;
        if (cmd.op == bkas_pkg::OP_MUL_AX) begin
          v2_r   <= prod_r[63:0];
          qneg_r <= a_ext[33] != x_r[33];
        end
      end
      bkas_pkg::OP_ADD:   prod_r <= {phi_r, 32'd0} + {2'd0, plo_r};
      bkas_pkg::OP_SH_S0: s0_r <= sh_res;
      bkas_pkg::OP_SH_T:  t_r <= sh_res;
      bkas_pkg::OP_DISC: begin
        rad_r  <= disc;
        rem_r  <= '0;
        root_r <= '0;
      end
      bkas_pkg::OP_SQRT: begin
        rad_r <= {rad_r[61:0], 2'b00};
        if (rem_cat >= trial) begin
          rem_r  <= 34'(rem_cat - trial);
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          rem_r  <= rem_cat[33:0];
          root_r <= {root_r[30:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign pos     = pos_r;
  assign vel     = vel_r;
  assign disp    = disp_r;
  assign prev    = prev_r;
  assign elapsed = time_r;

endmodule

@@ src/bkas_ctrl.sv @@
module bkas_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_mode,
  input  logic             frozen,
  input  logic             out_busy,
  input  bkas_pkg::stat_t  stat,
  output logic             in_ready,
  output logic             done,
  output bkas_pkg::cmd_t   cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_S0_MUL  = 5'd1;
  localparam logic [4:0] S_S0_ADD  = 5'd2;
  localparam logic [4:0] S_S0_SH   = 5'd3;
  localparam logic [4:0] S_T_MUL   = 5'd4;
  localparam logic [4:0] S_T_ADD   = 5'd5;
  localparam logic [4:0] S_T_SH    = 5'd6;
  localparam logic [4:0] S_LIMIT   = 5'd7;
  localparam logic [4:0] S_VV_MUL  = 5'd8;
  localparam logic [4:0] S_VV_ADD  = 5'd9;
  localparam logic [4:0] S_AX_MUL  = 5'd10;
  localparam logic [4:0] S_AX_ADD  = 5'd11;
  localparam logic [4:0] S_DISC    = 5'd12;
  localparam logic [4:0] S_SQRT    = 5'd13;
  localparam logic [4:0] S_ARR_END = 5'd14;
  localparam logic [4:0] S_BOUND   = 5'd15;
  localparam logic [4:0] S_CAP     = 5'd16;
  localparam logic [4:0] S_DONE    = 5'd17;

  logic [4:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       from_bound_r, from_bound_nxt;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    from_bound_nxt = from_bound_r;
    in_ready       = 1'b0;
    done           = 1'b0;
    cmd.op         = bkas_pkg::OP_NONE;
    cmd.load       = in_mode;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = bkas_pkg::OP_START;
          state_nxt = (in_mode || frozen) ? S_DONE : S_S0_MUL;
        end
      end
      S_S0_MUL: begin cmd.op = bkas_pkg::OP_MUL_S0; state_nxt = S_S0_ADD; end
      S_S0_ADD: begin cmd.op = bkas_pkg::OP_ADD;    state_nxt = S_S0_SH;  end
      S_S0_SH:  begin cmd.op = bkas_pkg::OP_SH_S0;  state_nxt = S_T_MUL;  end
      S_T_MUL:  begin cmd.op = bkas_pkg::OP_MUL_T;  state_nxt = S_T_ADD;  end
      S_T_ADD:  begin cmd.op = bkas_pkg::OP_ADD;    state_nxt = S_T_SH;   end
      S_T_SH:   begin cmd.op = bkas_pkg::OP_SH_T;   state_nxt = S_LIMIT;  end
      S_LIMIT: begin
        cmd.op         = bkas_pkg::OP_LIMIT;
        from_bound_nxt = 1'b0;
        state_nxt      = (stat.limited && !stat.a_zero) ? S_VV_MUL : S_BOUND;
      end
      S_VV_MUL: begin cmd.op = bkas_pkg::OP_MUL_VV; state_nxt = S_VV_ADD; end
      S_VV_ADD: begin cmd.op = bkas_pkg::OP_ADD;    state_nxt = S_AX_MUL; end
      S_AX_MUL: begin cmd.op = bkas_pkg::OP_MUL_AX; state_nxt = S_AX_ADD; end
      S_AX_ADD: begin cmd.op = bkas_pkg::OP_ADD;    state_nxt = S_DISC;   end
      S_DISC: begin
        cmd.op    = bkas_pkg::OP_DISC;
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op  = bkas_pkg::OP_SQRT;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) state_nxt = S_ARR_END;
      end
      S_ARR_END: begin
        cmd.op    = bkas_pkg::OP_ARR_END;
        state_nxt = from_bound_r ? S_CAP : S_BOUND;
      end
      S_BOUND: begin
        cmd.op = bkas_pkg::OP_BOUND;
        if (stat.bound_hit && !stat.a_zero) begin
          from_bound_nxt = 1'b1;
          state_nxt      = S_VV_MUL;
        end else begin
          state_nxt = S_CAP;
        end
      end
      S_CAP: begin cmd.op = bkas_pkg::OP_CAP; state_nxt = S_DONE; end
      S_DONE: begin
        if (!out_busy) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      from_bound_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      from_bound_r <= from_bound_nxt;
    end
  end

endmodule

@@ src/bounded_kinematic_axis_step.sv @@
// Channel | Direction | Words
// in_     | slave     | tdata: delta_time, load_position, load_velocity; tuser: mode
// out_    | master    | tdata: position, velocity, displacement, previous_position,
//         |           |        elapsed_time
// cfg_    | APB slave | six registers at byte addresses 0, 4, .. 20
//
// A load word or a frozen tick goes from idle to the done state and back to idle;
// a tick computes 0, 1 or 2 square roots, each a 32-step bit-serial square root.
// The result is offered in the same cycle as the controller returns to idle. A result
// still waiting in the output register holds the controller in its last state.
// Reset is synchronous and active low; it clears the controller, the output valid
// and the datapath's output registers and loads the configuration defaults.
module bounded_kinematic_axis_step #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // delta_time, load_position, load_velocity
  input  logic         in_tuser,   // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  // position, velocity, displacement, previous_position, elapsed_time
  output logic [175:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  bkas_pkg::cfg_t  cfg_r;
  bkas_pkg::cmd_t  cmd;
  bkas_pkg::stat_t stat;

  logic               done, out_valid_r;
  logic [175:0]       out_data_r;
  logic signed [31:0] pos, vel, disp, prev;
  logic [47:0]        elapsed;
  logic               wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.acceleration <= 32'sd0;
      cfg_r.max_step     <= 31'h7fffffff;
      cfg_r.low_bound    <= 32'sh80000000;
      cfg_r.high_bound   <= 32'sh7fffffff;
      cfg_r.velocity_cap <= 32'sh7fffffff;
      cfg_r.frozen       <= 1'b0;
    end else if (wr_en) begin
      case (cfg_paddr[4:2])
        bkas_pkg::REG_ACCELERATION: cfg_r.acceleration <= cfg_pwdata;
        bkas_pkg::REG_MAX_STEP:     cfg_r.max_step     <= cfg_pwdata[30:0];
        bkas_pkg::REG_LOW_BOUND:    cfg_r.low_bound    <= cfg_pwdata;
        bkas_pkg::REG_HIGH_BOUND:   cfg_r.high_bound   <= cfg_pwdata;
        bkas_pkg::REG_VELOCITY_CAP: cfg_r.velocity_cap <= cfg_pwdata;
        bkas_pkg::REG_FROZEN:       cfg_r.frozen       <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      bkas_pkg::REG_ACCELERATION: cfg_prdata = cfg_r.acceleration;
      bkas_pkg::REG_MAX_STEP:     cfg_prdata = {1'b0, cfg_r.max_step};
      bkas_pkg::REG_LOW_BOUND:    cfg_prdata = cfg_r.low_bound;
      bkas_pkg::REG_HIGH_BOUND:   cfg_prdata = cfg_r.high_bound;
      bkas_pkg::REG_VELOCITY_CAP: cfg_prdata = cfg_r.velocity_cap;
      bkas_pkg::REG_FROZEN:       cfg_prdata = {31'd0, cfg_r.frozen};
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  bkas_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_mode  (in_tuser),
    .frozen   (cfg_r.frozen),
    .out_busy (out_valid_r & ~out_tready),
    .stat     (stat),
    .in_ready (in_tready),
    .done     (done),
    .cmd      (cmd)
  );

  bkas_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .cmd     (cmd),
    .stat    (stat),
    .in_dt   (in_tdata[31:0]),
    .in_lpos (in_tdata[63:32]),
    .in_lvel (in_tdata[95:64]),
    .pos     (pos),
    .vel     (vel),
    .disp    (disp),
    .prev    (prev),
    .elapsed (elapsed)
  );

  // The output register frees the datapath once a finished word is parked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) out_data_r <= {elapsed, prev, disp, vel, pos};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
